FILE: rtl/pfmq_pkg.sv
// shared types and constants of the paced fan-out message queue
package pfmq_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned QueueDepthDefault    = 8;
  localparam int unsigned MaxRecipientsDefault = 16;

  // configuration register indexes (word address paddr[3:2])
  localparam logic [1:0] RegRecipientCount = 2'd0;
  localparam logic [1:0] RegSendSpacing    = 2'd1;
  localparam logic [1:0] RegRetryInterval  = 2'd2;

  // register reset values
  localparam logic [4:0]  RecipientCountReset = 5'd1;
  localparam logic [31:0] SendSpacingReset    = 32'd3000;
  localparam logic [31:0] RetryIntervalReset  = 32'd10000;

  // action codes of an input transaction
  localparam logic ActionEnqueue = 1'b0;
  localparam logic ActionTick    = 1'b1;

  // input transaction
  typedef struct packed {
    logic        action;
    logic [15:0] message_handle;
    logic [31:0] now_time;
    logic        link_up;
  } in_t;

  // result transaction
  typedef struct packed {
    logic        accepted;
    logic        reconnect_request;
    logic        send_valid;
    logic [3:0]  recipient_index;
    logic [15:0] sent_handle;
    logic        message_done;
    logic        discarded;
    logic [3:0]  queue_level;
  } out_t;

  // per-cell control: load from the write port or shift from the upper neighbor
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

FILE: rtl/pfmq_cell.sv
// one storage cell of the handle queue chain
module pfmq_cell
  import pfmq_pkg::*;
(
  input  logic        clk_i,
  input  cell_ctrl_t  ctrl_i,
  input  logic [15:0] wdata_i,
  input  logic [15:0] next_i,
  output logic [15:0] data_o
);

  logic [15:0] data_q;
  logic [15:0] data_d;

  // a new handle lands here, or the upper neighbor moves down on a pop
  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = wdata_i;
    end else if (ctrl_i.shift) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/pfmq_chain.sv
// row of handle cells: head at cell 0, pop shifts every cell down by one
module pfmq_chain
  import pfmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  localparam int unsigned FillW      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             push_i,
  input  logic             pop_i,
  input  logic [FillW-1:0] tail_i,
  input  logic [15:0]      wdata_i,
  output logic [15:0]      head_o
);

  logic [15:0] cell_data [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t  ctrl;
    logic [15:0] upper;

    // only the cell at the tail position takes a pushed handle
    assign ctrl.load  = push_i && (tail_i == FillW'(i));
    assign ctrl.shift = pop_i;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign upper = wdata_i;
    end else begin : g_mid
      assign upper = cell_data[i+1];
    end

    pfmq_cell u_pfmq_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .wdata_i (wdata_i),
      .next_i  (upper),
      .data_o  (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

FILE: rtl/paced_fanout_message_queue_top.sv
// top level of the paced fan-out message queue: config registers, pacing control, result
//
// channel   | direction | handshake                          | payload
// ----------+-----------+------------------------------------+----------------------
// command   | in        | start high while busy low          | in_data_i (in_t)
// result    | out       | result_valid_o high for one cycle  | result_o (out_t)
// config    | in/out    | psel, penable, pwrite, pready high | pwdata / prdata
//
// every transaction produces exactly one result, in the cycle after it is taken
// busy stays low: a transaction is taken on every cycle that start is high, with
// combinational compares, counter updates and at most one cell-chain access each
// reset clears the queue fill count, recipient counter and time stamps, and sets the registers to their reset values
// results are never held back: the receiver takes each one in its single strobe cycle
module paced_fanout_message_queue_top
  import pfmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH    = QueueDepthDefault,
  parameter int unsigned MAX_RECIPIENTS = MaxRecipientsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data_i,
  output logic        result_valid_o,
  output out_t        result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned FillW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CntRaw = $clog2(MAX_RECIPIENTS + 1);
  localparam int unsigned CntW   = (CntRaw > 5) ? CntRaw : 5;

  // configuration registers
  logic [4:0]  rcount_q;
  logic [31:0] spacing_q;
  logic [31:0] retry_q;

  // control state
  logic [FillW-1:0] fill_q, fill_d;
  logic [CntW-1:0]  recip_q, recip_d;
  logic [31:0]      last_send_q, last_send_d;
  logic [31:0]      last_retry_q, last_retry_d;

  // result register
  logic result_valid_q;
  out_t result_q, result_d;

  logic        accept;
  logic        cfg_write;
  logic        push;
  logic        pop;
  logic [15:0] head;
  logic [CntW-1:0]  count_ext;
  logic [CntW-1:0]  count_eff;
  logic [CntW-1:0]  recip_next;
  logic [FillW+3:0] level_wide;
  logic [CntW+3:0]  index_wide;
  logic             retry_due;
  logic             send_due;
  logic             full;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcount_q  <= RecipientCountReset;
      spacing_q <= SendSpacingReset;
      retry_q   <= RetryIntervalReset;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        RegRecipientCount: rcount_q  <= pwdata[4:0];
        RegSendSpacing:    spacing_q <= pwdata;
        RegRetryInterval:  retry_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      RegRecipientCount: prdata = {27'd0, rcount_q};
      RegSendSpacing:    prdata = spacing_q;
      RegRetryInterval:  prdata = retry_q;
      default:           prdata = 32'd0;
    endcase
  end

  // recipient count clamped to the supported maximum
  assign count_ext = CntW'(rcount_q);
  assign count_eff = (count_ext > CntW'(MAX_RECIPIENTS)) ? CntW'(MAX_RECIPIENTS) : count_ext;
  assign recip_next = recip_q + CntW'(1);

  // wrapping elapsed-time checks
  assign retry_due = (in_data_i.now_time - last_retry_q) >= retry_q;
  assign send_due  = (in_data_i.now_time - last_send_q) >= spacing_q;
  assign full      = (fill_q == FillW'(QUEUE_DEPTH));

  // per-transaction decision
  always_comb begin
    fill_d       = fill_q;
    recip_d      = recip_q;
    last_send_d  = last_send_q;
    last_retry_d = last_retry_q;
    push         = 1'b0;
    pop          = 1'b0;
    result_d     = '0;

    if (in_data_i.action == ActionEnqueue) begin
      if (!full) begin
        push              = 1'b1;
        fill_d            = fill_q + FillW'(1);
        result_d.accepted = 1'b1;
      end
    end else if (!in_data_i.link_up) begin
      if (retry_due) begin
        last_retry_d               = in_data_i.now_time;
        result_d.reconnect_request = 1'b1;
      end
    end else if ((fill_q != '0) && send_due) begin
      if (count_eff == '0) begin
        pop               = 1'b1;
        fill_d            = fill_q - FillW'(1);
        result_d.discarded = 1'b1;
      end else begin
        result_d.send_valid  = 1'b1;
        result_d.sent_handle = head;
        last_send_d          = in_data_i.now_time;
        if (recip_next >= count_eff) begin
          recip_d               = '0;
          pop                   = 1'b1;
          fill_d                = fill_q - FillW'(1);
          result_d.message_done = 1'b1;
        end else begin
          recip_d = recip_next;
        end
      end
    end

    index_wide               = {4'd0, recip_q};
    result_d.recipient_index = result_d.send_valid ? index_wide[3:0] : 4'd0;
    level_wide               = {4'd0, fill_d};
    result_d.queue_level     = level_wide[3:0];
  end

  // control state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q         <= '0;
      recip_q        <= '0;
      last_send_q    <= '0;
      last_retry_q   <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= accept;
      if (accept) begin
        fill_q       <= fill_d;
        recip_q      <= recip_d;
        last_send_q  <= last_send_d;
        last_retry_q <= last_retry_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // handle storage chain
  pfmq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_pfmq_chain (
    .clk_i   (clk_i),
    .push_i  (accept && push),
    .pop_i   (accept && pop),
    .tail_i  (fill_q),
    .wdata_i (in_data_i.message_handle),
    .head_o  (head)
  );

endmodule
